// ===== src/binary_max_heap_queue_defines.svh =====
// Assertion macros for the binary max-heap queue.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define BMHQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap queue check failed");
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap queue check failed");
`else
`define BMHQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bmhq_pkg.sv =====
// Types and codes shared by the binary max-heap queue.
package bmhq_pkg;

	localparam logic [1:0] ACT_INSERT     = 2'd0;
	localparam logic [1:0] ACT_REMOVE_MAX = 2'd1;
	localparam logic [1:0] ACT_CHANGE     = 2'd2;
	localparam logic [1:0] ACT_REMOVE_AT  = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] key_value;
		logic [6:0]         heap_index;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic signed [31:0] removed_value;
		logic [6:0]         entry_count;
		logic [1:0]         status;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LDA,
		ST_LDB,
		ST_LDC,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_RL,
		ST_DN_RR,
		ST_TOP,
		ST_FIN
	} state_t;

endpackage

// ===== src/bmhq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bmhq_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue.
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one action per item:
//   insert, remove max, change key at index or remove at index.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one item per command
//   with the maximum key, any removed key, the entry count and a status.
//   One command is worked on at a time; cmd_stall is high while busy.
//   Errors (full, empty, bad index) go straight to the end read. An insert
//   climbs from the new last position, one parent read per level. A remove
//   or change passes through its load states, then climbs or descends,
//   reading one parent or child per step, and ends with a read of the root.
//   The next command is taken in the cycle after the result is registered.
//   The pace of the sift loop is set by the single read port of the key
//   RAM, which the loop visits once per parent or child.
//   Reset clears the fill count; RAM contents stay undefined, and values read
//   outside the filled range are never used. No clearing pass is needed.
//   A stalled result is held in the output register; the block finishes the
//   next command up to its end read and waits there for the slot to free.
`include "binary_max_heap_queue_defines.svh"
module binary_max_heap_queue #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  bmhq_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bmhq_pkg::rsp_item_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = CW + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int MW = (PW > 7) ? PW : 7;

	bmhq_pkg::state_t state_q, state_d;

	logic [1:0]                 act_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [MW-1:0]              idx_q;
	logic [CW-1:0]              cnt_q;
	logic [PW-1:0]              pos_q;
	logic signed [KEY_BITS-1:0] cur_q;
	logic signed [KEY_BITS-1:0] old_q;
	logic signed [KEY_BITS-1:0] lv_q;
	logic signed [KEY_BITS-1:0] removed_q;
	logic [1:0]                 status_q;
	logic                       rsp_valid_q;
	bmhq_pkg::rsp_item_t        rsp_q;

	logic                       cmd_acc;
	logic                       slot_free;
	logic signed [KEY_BITS-1:0] cmd_key;
	logic [MW-1:0]              cmd_idx;
	logic [PW-1:0]              cnt_p;
	logic [PW-1:0]              cnt_m1_p;
	logic [PW-1:0]              lpos;
	logic [PW-1:0]              rpos;
	logic                       l_in;
	logic                       r_in;
	logic signed [KEY_BITS-1:0] rdata;
	logic                       cur_gt_rd;
	logic                       lv_gt_cur;
	logic [PW-1:0]              big_pos;
	logic signed [KEY_BITS-1:0] big_val;
	logic                       rd_gt_big;
	logic [PW-1:0]              rd_pos;
	logic                       ram_we;
	logic [PW-1:0]              wr_pos;
	logic signed [KEY_BITS-1:0] wr_key;
	logic [AW-1:0]              raddr;
	logic [AW-1:0]              waddr;

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != bmhq_pkg::ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_key   = KEY_BITS'(64'(cmd.key_value));
	assign cmd_idx   = MW'(cmd.heap_index);
	assign cnt_p     = PW'(cnt_q);
	assign cnt_m1_p  = cnt_p - PW'(1);
	assign lpos      = {pos_q[PW-2:0], 1'b0};
	assign rpos      = {pos_q[PW-2:0], 1'b1};
	assign l_in      = (lpos <= cnt_p);
	assign r_in      = (rpos <= cnt_p);
	assign cur_gt_rd = (cur_q > rdata);
	assign lv_gt_cur = (lv_q > cur_q);
	assign big_pos   = lv_gt_cur ? lpos : pos_q;
	assign big_val   = lv_gt_cur ? lv_q : cur_q;
	assign rd_gt_big = (rdata > big_val);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.action == bmhq_pkg::ACT_INSERT) begin
						state_d = (cnt_q >= CW'(DEPTH)) ? bmhq_pkg::ST_TOP
							: bmhq_pkg::ST_UP_RD;
					end else if (cnt_q == '0) begin
						state_d = bmhq_pkg::ST_TOP;
					end else if (cmd.action == bmhq_pkg::ACT_REMOVE_MAX) begin
						state_d = bmhq_pkg::ST_LDA;
					end else if (cmd_idx == '0 || cmd_idx > MW'(cnt_q)) begin
						state_d = bmhq_pkg::ST_TOP;
					end else begin
						state_d = bmhq_pkg::ST_LDA;
					end
				end
			end
			bmhq_pkg::ST_LDA: state_d = bmhq_pkg::ST_LDB;
			bmhq_pkg::ST_LDB: state_d = bmhq_pkg::ST_LDC;
			bmhq_pkg::ST_LDC: begin
				case (act_q)
					bmhq_pkg::ACT_REMOVE_MAX: begin
						state_d = (cnt_m1_p == '0) ? bmhq_pkg::ST_TOP
							: bmhq_pkg::ST_DN_RD;
					end
					bmhq_pkg::ACT_CHANGE: begin
						state_d = (key_q > old_q) ? bmhq_pkg::ST_UP_RD
							: bmhq_pkg::ST_DN_RD;
					end
					default: begin
						if (PW'(idx_q) > cnt_m1_p) begin
							state_d = bmhq_pkg::ST_TOP;
						end else begin
							state_d = (rdata > old_q) ? bmhq_pkg::ST_UP_RD
								: bmhq_pkg::ST_DN_RD;
						end
					end
				endcase
			end
			bmhq_pkg::ST_UP_RD: begin
				state_d = (pos_q == PW'(1)) ? bmhq_pkg::ST_TOP : bmhq_pkg::ST_UP_CMP;
			end
			bmhq_pkg::ST_UP_CMP: begin
				state_d = cur_gt_rd ? bmhq_pkg::ST_UP_RD : bmhq_pkg::ST_TOP;
			end
			bmhq_pkg::ST_DN_RD: begin
				state_d = l_in ? bmhq_pkg::ST_DN_RL : bmhq_pkg::ST_TOP;
			end
			bmhq_pkg::ST_DN_RL: begin
				if (r_in) begin
					state_d = bmhq_pkg::ST_DN_RR;
				end else begin
					state_d = (rdata > cur_q) ? bmhq_pkg::ST_DN_RD : bmhq_pkg::ST_TOP;
				end
			end
			bmhq_pkg::ST_DN_RR: begin
				state_d = (rd_gt_big || lv_gt_cur) ? bmhq_pkg::ST_DN_RD
					: bmhq_pkg::ST_TOP;
			end
			bmhq_pkg::ST_TOP: state_d = bmhq_pkg::ST_FIN;
			bmhq_pkg::ST_FIN: begin
				if (slot_free) begin
					state_d = bmhq_pkg::ST_IDLE;
				end
			end
			default: state_d = bmhq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_pos = PW'(1);
		ram_we = 1'b0;
		wr_pos = pos_q;
		wr_key = cur_q;
		case (state_q)
			bmhq_pkg::ST_LDA: begin
				rd_pos = (act_q == bmhq_pkg::ACT_REMOVE_MAX) ? PW'(1) : PW'(idx_q);
			end
			bmhq_pkg::ST_LDB: rd_pos = cnt_p;
			bmhq_pkg::ST_UP_RD: begin
				rd_pos = pos_q >> 1;
				ram_we = (pos_q == PW'(1));
			end
			bmhq_pkg::ST_UP_CMP: begin
				ram_we = 1'b1;
				wr_key = cur_gt_rd ? rdata : cur_q;
			end
			bmhq_pkg::ST_DN_RD: begin
				rd_pos = lpos;
				ram_we = !l_in;
			end
			bmhq_pkg::ST_DN_RL: begin
				rd_pos = rpos;
				ram_we = !r_in;
				wr_key = (rdata > cur_q) ? rdata : cur_q;
			end
			bmhq_pkg::ST_DN_RR: begin
				ram_we = 1'b1;
				wr_key = rd_gt_big ? rdata : big_val;
			end
			default: begin
				rd_pos = PW'(1);
			end
		endcase
	end

	assign raddr = AW'(rd_pos - PW'(1));
	assign waddr = AW'(wr_pos - PW'(1));

	bmhq_ram #(
		.W(KEY_BITS),
		.D(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wr_key),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmhq_pkg::ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bmhq_pkg::ST_IDLE && cmd_valid &&
			    cmd.action == bmhq_pkg::ACT_INSERT && cnt_q < CW'(DEPTH)) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == bmhq_pkg::ST_LDC && act_q != bmhq_pkg::ACT_CHANGE) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == bmhq_pkg::ST_FIN && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				act_q     <= cmd.action;
				key_q     <= cmd_key;
				idx_q     <= cmd_idx;
				cur_q     <= cmd_key;
				pos_q     <= cnt_p + PW'(1);
				removed_q <= '0;
				if (cmd.action == bmhq_pkg::ACT_INSERT) begin
					status_q <= (cnt_q >= CW'(DEPTH)) ? bmhq_pkg::STAT_FULL
						: bmhq_pkg::STAT_OK;
				end else if (cnt_q == '0) begin
					status_q <= bmhq_pkg::STAT_EMPTY;
				end else if (cmd.action != bmhq_pkg::ACT_REMOVE_MAX &&
				             (cmd_idx == '0 || cmd_idx > MW'(cnt_q))) begin
					status_q <= bmhq_pkg::STAT_BAD_INDEX;
				end else begin
					status_q <= bmhq_pkg::STAT_OK;
				end
			end
			bmhq_pkg::ST_LDB: old_q <= rdata;
			bmhq_pkg::ST_LDC: begin
				case (act_q)
					bmhq_pkg::ACT_REMOVE_MAX: begin
						removed_q <= old_q;
						cur_q     <= rdata;
						pos_q     <= PW'(1);
					end
					bmhq_pkg::ACT_CHANGE: begin
						cur_q <= key_q;
						pos_q <= PW'(idx_q);
					end
					default: begin
						removed_q <= old_q;
						cur_q     <= rdata;
						pos_q     <= PW'(idx_q);
					end
				endcase
			end
			bmhq_pkg::ST_UP_CMP: begin
				if (cur_gt_rd) begin
					pos_q <= pos_q >> 1;
				end
			end
			bmhq_pkg::ST_DN_RL: begin
				lv_q <= rdata;
				if (!r_in && rdata > cur_q) begin
					pos_q <= lpos;
				end
			end
			bmhq_pkg::ST_DN_RR: begin
				pos_q <= rd_gt_big ? rpos : big_pos;
			end
			bmhq_pkg::ST_FIN: begin
				if (slot_free) begin
					rsp_q.top_value     <= (cnt_q == '0) ? 32'sd0 : 32'(64'(rdata));
					rsp_q.removed_value <= 32'(64'(removed_q));
					rsp_q.entry_count   <= 7'(cnt_q);
					rsp_q.status        <= status_q;
				end
			end
			default: begin
				lv_q <= lv_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BMHQ_ASSERT_IMPLY(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`BMHQ_ASSERT_IMPLY(a_wr_in_range, clk, arst_n, ram_we, wr_pos >= PW'(1) && wr_pos <= cnt_p)
	`BMHQ_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, cmd_acc, state_q != bmhq_pkg::ST_IDLE)

endmodule

// ===== sim/binary_max_heap_queue_test.sv =====
// Self-checking testbench for the binary max-heap queue: predicts every result item and compares.
module binary_max_heap_queue_test;

	localparam int HEAP_DEPTH = 64;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	bmhq_pkg::cmd_item_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	bmhq_pkg::rsp_item_t rsp;

	logic signed [31:0] heap_keys [1:HEAP_DEPTH];
	int unsigned heap_fill;
	bmhq_pkg::rsp_item_t expected_rsps [$];
	int unsigned mismatches;
	int unsigned rsp_hold_cycles;
	bit rsp_idle_off;

	binary_max_heap_queue #(.DEPTH(HEAP_DEPTH), .KEY_BITS(32)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void swap_keys(int unsigned a, int unsigned b);
		logic signed [31:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	function automatic void climb(int unsigned i);
		while (i > 1 && heap_keys[i] > heap_keys[i / 2]) begin
			swap_keys(i, i / 2);
			i = i / 2;
		end
	endfunction

	function automatic void descend(int unsigned i);
		int unsigned big;
		forever begin
			big = i;
			if (2 * i <= heap_fill && heap_keys[2 * i] > heap_keys[big]) big = 2 * i;
			if (2 * i + 1 <= heap_fill && heap_keys[2 * i + 1] > heap_keys[big]) big = 2 * i + 1;
			if (big == i) return;
			swap_keys(i, big);
			i = big;
		end
	endfunction

	function automatic bmhq_pkg::rsp_item_t apply_action(bmhq_pkg::cmd_item_t c);
		bmhq_pkg::rsp_item_t r;
		logic signed [31:0] old_key;
		logic signed [31:0] last_key;
		int unsigned idx;
		r = '0;
		idx = c.heap_index;
		if (c.action == bmhq_pkg::ACT_INSERT) begin
			if (heap_fill >= HEAP_DEPTH) r.status = bmhq_pkg::STAT_FULL;
			else begin
				heap_fill++;
				heap_keys[heap_fill] = c.key_value;
				climb(heap_fill);
			end
		end else if (heap_fill == 0) begin
			r.status = bmhq_pkg::STAT_EMPTY;
		end else if (c.action == bmhq_pkg::ACT_REMOVE_MAX) begin
			r.removed_value = heap_keys[1];
			heap_keys[1] = heap_keys[heap_fill];
			heap_fill--;
			descend(1);
		end else if (idx < 1 || idx > heap_fill) begin
			r.status = bmhq_pkg::STAT_BAD_INDEX;
		end else if (c.action == bmhq_pkg::ACT_CHANGE) begin
			old_key = heap_keys[idx];
			heap_keys[idx] = c.key_value;
			if (c.key_value > old_key) climb(idx);
			else descend(idx);
		end else begin
			old_key = heap_keys[idx];
			last_key = heap_keys[heap_fill];
			r.removed_value = old_key;
			heap_fill--;
			if (idx <= heap_fill) begin
				heap_keys[idx] = last_key;
				if (last_key > old_key) climb(idx);
				else descend(idx);
			end
		end
		r.top_value = (heap_fill != 0) ? heap_keys[1] : 32'sd0;
		r.entry_count = heap_fill[6:0];
		return r;
	endfunction

	// offer one item; valid stays up only when the next item follows at once
	task automatic send_item(bmhq_pkg::cmd_item_t c, bit no_gap = 0);
		int unsigned gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		expected_rsps.push_back(apply_action(c));
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] edge_key();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sd0;
			3: return $signed($urandom_range(0, 8)) - 4;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic bmhq_pkg::cmd_item_t pick_cmd(int unsigned insert_weight);
		bmhq_pkg::cmd_item_t c;
		c.key_value = edge_key();
		c.action = ($urandom_range(0, 99) < insert_weight) ? bmhq_pkg::ACT_INSERT :
			2'($urandom_range(1, 3));
		if ($urandom_range(0, 9) == 0) c.heap_index = 7'($urandom());
		else c.heap_index = 7'($urandom_range(1, (heap_fill > 0) ? heap_fill : 1));
		return c;
	endfunction

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// receiver: random stall per item, or held off for a counted stretch
	initial begin
		int unsigned wait_cycles;
		rsp_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles != 0) begin
				rsp_stall <= 1'b1;
				rsp_hold_cycles--;
			end else begin
				wait_cycles = rsp_idle_off ? 0 : (($urandom_range(0, 3) == 0) ? 0 :
					$urandom_range(0, 17));
				if (wait_cycles == 0) rsp_stall <= 1'b0;
				else begin
					rsp_stall <= 1'b1;
					repeat (wait_cycles - 1) @(negedge clk);
					@(negedge clk);
					rsp_stall <= 1'b0;
				end
				@(posedge clk);
				while (!rsp_valid && rsp_hold_cycles == 0) @(posedge clk);
			end
		end
	end

	initial begin
		bmhq_pkg::rsp_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected item %p", $time, rsp);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.top_value !== want.top_value)
						$display("%0t: top_value expected %0d actual %0d", $time,
							want.top_value, rsp.top_value);
					if (rsp.removed_value !== want.removed_value)
						$display("%0t: removed_value expected %0d actual %0d", $time,
							want.removed_value, rsp.removed_value);
					if (rsp.entry_count !== want.entry_count)
						$display("%0t: entry_count expected %0d actual %0d", $time,
							want.entry_count, rsp.entry_count);
					if (rsp.status !== want.status)
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp.status);
					if (rsp !== want) mismatches++;
				end
			end
		end
	end

	task automatic test_empty_errors();
		bmhq_pkg::cmd_item_t c;
		c = '0;
		for (int a = 1; a <= 3; a++) begin
			c.action = 2'(a);
			c.heap_index = 7'd1;
			send_item(c);
		end
	endtask

	task automatic test_directed();
		bmhq_pkg::cmd_item_t c;
		c = '0;
		c.action = bmhq_pkg::ACT_INSERT;
		c.key_value = 32'sh8000_0000; send_item(c);
		c.key_value = 32'sh7fff_ffff; send_item(c);
		c.key_value = 32'sd5; send_item(c);
		c.key_value = 32'sd5; send_item(c);
		c.key_value = -32'sd1; send_item(c);
		c.action = bmhq_pkg::ACT_CHANGE;
		c.heap_index = 7'd0; send_item(c);
		c.heap_index = 7'd127; send_item(c);
		c.heap_index = 7'd6; send_item(c);
		c.heap_index = 7'd3; c.key_value = 32'sh7fff_ffff; send_item(c);
		c.heap_index = 7'd2; c.key_value = 32'sh8000_0000; send_item(c);
		c.heap_index = 7'd1; c.key_value = 32'sh8000_0000; send_item(c);
		c.action = bmhq_pkg::ACT_REMOVE_AT;
		c.heap_index = 7'd5; send_item(c);
		c.heap_index = 7'd1; send_item(c);
		c.heap_index = 7'd64; send_item(c);
		c.action = bmhq_pkg::ACT_REMOVE_MAX; send_item(c);
		c.action = bmhq_pkg::ACT_REMOVE_AT; c.heap_index = 7'd2; send_item(c);
		c.heap_index = 7'd1; send_item(c);
		drain();
	endtask

	task automatic test_fill_to_full();
		// sender keeps offering while receiver holds off
		rsp_hold_cycles = 200;
		for (int i = 0; i < HEAP_DEPTH + 3; i++) send_item(pick_cmd(100), 1);
		drain();
		for (int i = 0; i < HEAP_DEPTH + 2; i++) send_item(pick_cmd(0));
		drain();
	endtask

	task automatic test_random();
		int unsigned weight;
		for (int n = 0; n < 1900; n++) begin
			if (n % 200 == 0) weight = $urandom_range(20, 80);
			rsp_idle_off = (n / 100) % 5 == 2;
			send_item(pick_cmd(weight), (n / 100) % 5 == 2);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		heap_fill = 0;
		mismatches = 0;
		rsp_hold_cycles = 0;
		rsp_idle_off = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_errors();
		test_directed();
		test_fill_to_full();
		test_random();
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/binary_max_heap_queue.sv
sim/binary_max_heap_queue_test.sv
